>>> src/ddtk_pkg.sv
package ddtk_pkg;

    // Field widths of the beats and of the configuration registers.
    localparam int IDX_W   = 11;
    localparam int SIZE_W  = 16;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 16;
    localparam int REG_IDX_W = 3;
    localparam int RATIO_W = 32;
    localparam int MANT_W  = 32;
    localparam int EXP_W   = 7;

    // Largest cell count that is honored; larger counts are clamped.
    localparam int MAX_CELLS = 1024;

    // Internal datapath widths.
    localparam int AXES    = 3;
    localparam int LANES   = 6;
    localparam int OFF_W   = 13;
    localparam int POS_W   = 29;
    localparam int SQ_W    = 56;
    localparam int NUM_W   = 58;
    localparam int RN_W    = 62;
    localparam int K_W     = 5;
    localparam int ROOT_W  = 31;
    localparam int SQRT_REM_W  = 33;
    localparam int RATIO_REM_W = 59;
    localparam int SCALE_REM_W = 64;
    localparam int EXPC_W  = EXP_W + 1;

    // Number of cells in each chain.
    localparam int RATIO_STEPS = 30;
    localparam int NORM_STEPS  = 5;
    localparam int SQRT_STEPS  = 31;
    localparam int SCALE_STEPS = 33;

    // Ratio lanes.
    localparam int LANE_XX = 0;
    localparam int LANE_YY = 1;
    localparam int LANE_ZZ = 2;
    localparam int LANE_XY = 3;
    localparam int LANE_XZ = 4;
    localparam int LANE_YZ = 5;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CELL_SIZE_X = 3'd0,
        REG_CELL_SIZE_Y = 3'd1,
        REG_CELL_SIZE_Z = 3'd2,
        REG_CELLS_X     = 3'd3,
        REG_CELLS_Y     = 3'd4,
        REG_CELLS_Z     = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [IDX_W-1:0] index_x;
        logic [IDX_W-1:0] index_y;
        logic [IDX_W-1:0] index_z;
    } item_t;

    typedef struct packed {
        logic signed [RATIO_W-1:0] ratio_xx;
        logic signed [RATIO_W-1:0] ratio_yy;
        logic signed [RATIO_W-1:0] ratio_zz;
        logic signed [RATIO_W-1:0] ratio_xy;
        logic signed [RATIO_W-1:0] ratio_xz;
        logic signed [RATIO_W-1:0] ratio_yz;
        logic [MANT_W-1:0]         scale_mantissa;
        logic [EXP_W-1:0]          scale_exponent;
        logic                      at_origin;
    } result_t;

endpackage

>>> src/ddtk_delay.sv
module ddtk_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         clk,
    input  logic [W-1:0] data,
    output logic [W-1:0] delayed
);

    logic [DEPTH-1:0][W-1:0] line_reg;
    logic [DEPTH-1:0][W-1:0] line_next;

    always_comb
    begin
        line_next[0] = data;
        for (int i = 1; i < DEPTH; i++)
        begin
            line_next[i] = line_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

    assign delayed = line_reg[DEPTH-1];

endmodule

>>> src/ddtk_div_cell.sv
module ddtk_div_cell #(
    parameter int LANES = 1,
    parameter int REM_W = 8,
    parameter int QUO_W = 8
) (
    input  logic                         clk,
    input  logic [REM_W-1:0]             den,
    input  logic [LANES-1:0][REM_W-1:0]  rem,
    input  logic [LANES-1:0][QUO_W-1:0]  quo,
    output logic [REM_W-1:0]             den_fwd,
    output logic [LANES-1:0][REM_W-1:0]  rem_fwd,
    output logic [LANES-1:0][QUO_W-1:0]  quo_fwd
);

    // One restoring division step per lane; the remainder stays below den.
    logic [REM_W-1:0]             den_reg;
    logic [LANES-1:0][REM_W-1:0]  rem_reg;
    logic [LANES-1:0][QUO_W-1:0]  quo_reg;
    logic [LANES-1:0][REM_W-1:0]  rem_next;
    logic [LANES-1:0][QUO_W-1:0]  quo_next;
    logic [LANES-1:0][REM_W-1:0]  shifted;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            shifted[l] = {rem[l][REM_W-2:0], 1'b0};
            if (shifted[l] >= den)
            begin
                rem_next[l] = shifted[l] - den;
                quo_next[l] = {quo[l][QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = shifted[l];
                quo_next[l] = {quo[l][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign den_fwd = den_reg;
    assign rem_fwd = rem_reg;
    assign quo_fwd = quo_reg;

endmodule

>>> src/ddtk_sqrt_cell.sv
module ddtk_sqrt_cell #(
    parameter int RAD_W  = 8,
    parameter int REM_W  = 5,
    parameter int ROOT_W = 4
) (
    input  logic              clk,
    input  logic [RAD_W-1:0]  rad,
    input  logic [REM_W-1:0]  rem,
    input  logic [ROOT_W-1:0] root,
    output logic [RAD_W-1:0]  rad_fwd,
    output logic [REM_W-1:0]  rem_fwd,
    output logic [ROOT_W-1:0] root_fwd
);

    // One root bit per cell: two radicand bits enter the partial remainder.
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0]  rad_next;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [REM_W+1:0]  partial;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        partial  = {rem, rad[RAD_W-1 -: 2]};
        trial    = (REM_W+2)'({root, 2'b01});
        rad_next = {rad[RAD_W-3:0], 2'b00};
        if (partial >= trial)
        begin
            rem_next  = REM_W'(partial - trial);
            root_next = {root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = REM_W'(partial);
            root_next = {root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rad_fwd  = rad_reg;
    assign rem_fwd  = rem_reg;
    assign root_fwd = root_reg;

endmodule

>>> src/dipole_demag_tensor_kernel_unit.sv
// Channel  Handshake          Payload   Notes
// -------  -----------------  --------  ---------------------------------------
// input    start / busy       item      beat taken when start is high, busy low
// result   done (strobe)      result    valid for the one cycle done is high
// config   wr_en              wr_index  wr_data written at the edge, no wait
//
// The block accepts one beat in every cycle; busy is never raised.
// Results leave in the order their beats were taken; the pipeline's depth
// is set by the r^-3 path: normalizer (5), square root (31), multiplier (1),
// quotient setup (1), reciprocal divider (33), rounding (1) and the front (4).
// Reset sets the config registers to one and empties the pipeline's valid line.
// The receiver cannot stall, so the pipeline never holds: every stage
// advances in every cycle.
module dipole_demag_tensor_kernel_unit
    import ddtk_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                item,
    output logic                 done,
    output result_t              result,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    // Stage numbers count registers from the accepting edge.
    localparam int L_R     = 4;
    localparam int L_RATIO = L_R + 1 + RATIO_STEPS + 1;
    localparam int L_NORM  = L_R + NORM_STEPS;
    localparam int L_ROOT  = L_NORM + SQRT_STEPS;
    localparam int L_PROD  = L_ROOT + 1;
    localparam int L_QN    = L_PROD + 1;
    localparam int L_SDIV  = L_QN + SCALE_STEPS;
    localparam int LAT     = L_SDIV + 1;

    localparam logic [SCALE_REM_W-1:0] SCALE_NUM = SCALE_REM_W'(1) << (RN_W - 1);

    // Configuration registers.
    logic [AXES-1:0][SIZE_W-1:0] size_reg;
    logic [AXES-1:0][CNT_W-1:0]  cells_reg;
    logic [AXES-1:0][SIZE_W-1:0] size_next;
    logic [AXES-1:0][CNT_W-1:0]  cells_next;

    always_comb
    begin
        size_next  = size_reg;
        cells_next = cells_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_CELL_SIZE_X: size_next[0]  = wr_data;
                REG_CELL_SIZE_Y: size_next[1]  = wr_data;
                REG_CELL_SIZE_Z: size_next[2]  = wr_data;
                REG_CELLS_X:     cells_next[0] = wr_data[CNT_W-1:0];
                REG_CELLS_Y:     cells_next[1] = wr_data[CNT_W-1:0];
                REG_CELLS_Z:     cells_next[2] = wr_data[CNT_W-1:0];
                default:         size_next     = size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                size_reg[a]  <= SIZE_W'(1);
                cells_reg[a] <= CNT_W'(1);
            end
        end
        else
        begin
            size_reg  <= size_next;
            cells_reg <= cells_next;
        end
    end

    // Handshake and valid line.
    logic           accept;
    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] valid_next;

    assign busy       = 1'b0;
    assign accept     = start & ~busy;
    assign valid_next = {valid_reg[LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Front: offsets, positions, squares and products, then r^2 and numerators.
    logic [AXES-1:0][IDX_W-1:0]  idx;
    logic [AXES-1:0][CNT_W-1:0]  cells_c;
    logic [AXES-1:0][OFF_W-1:0]  off_reg;
    logic [AXES-1:0][OFF_W-1:0]  off_next;
    logic [AXES-1:0][POS_W-1:0]  pos_reg;
    logic [AXES-1:0][POS_W-1:0]  pos_next;
    logic [AXES-1:0][SQ_W-1:0]   sq_reg;
    logic [AXES-1:0][SQ_W-1:0]   sq_next;
    logic [AXES-1:0][NUM_W-1:0]  cross_reg;
    logic [AXES-1:0][NUM_W-1:0]  cross_next;
    logic [SQ_W-1:0]             r_reg;
    logic [SQ_W-1:0]             r_next;
    logic [LANES-1:0][NUM_W-1:0] num_reg;
    logic [LANES-1:0][NUM_W-1:0] num_next;
    logic [AXES-1:0][NUM_W-1:0]  sq_ext;

    assign idx[0] = item.index_x;
    assign idx[1] = item.index_y;
    assign idx[2] = item.index_z;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            cells_c[a]  = (int'(cells_reg[a]) > MAX_CELLS) ? CNT_W'(MAX_CELLS)
                                                           : cells_reg[a];
            off_next[a] = OFF_W'(idx[a]) - OFF_W'(cells_c[a]) + OFF_W'(1);
            pos_next[a] = POS_W'($signed(off_reg[a]) * $signed({1'b0, size_reg[a]}));
            sq_next[a]  = SQ_W'($signed(pos_reg[a]) * $signed(pos_reg[a]));
            sq_ext[a]   = NUM_W'(sq_reg[a]);
        end
        cross_next[0] = NUM_W'($signed(pos_reg[0]) * $signed(pos_reg[1]));
        cross_next[1] = NUM_W'($signed(pos_reg[0]) * $signed(pos_reg[2]));
        cross_next[2] = NUM_W'($signed(pos_reg[1]) * $signed(pos_reg[2]));
        r_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        num_next[LANE_XX] = sq_ext[1] + sq_ext[2] - {sq_ext[0][NUM_W-2:0], 1'b0};
        num_next[LANE_YY] = sq_ext[0] + sq_ext[2] - {sq_ext[1][NUM_W-2:0], 1'b0};
        num_next[LANE_ZZ] = sq_ext[0] + sq_ext[1] - {sq_ext[2][NUM_W-2:0], 1'b0};
        num_next[LANE_XY] = NUM_W'(0) - (cross_reg[0] + {cross_reg[0][NUM_W-2:0], 1'b0});
        num_next[LANE_XZ] = NUM_W'(0) - (cross_reg[1] + {cross_reg[1][NUM_W-2:0], 1'b0});
        num_next[LANE_YZ] = NUM_W'(0) - (cross_reg[2] + {cross_reg[2][NUM_W-2:0], 1'b0});
    end

    always_ff @(posedge clk)
    begin
        off_reg   <= off_next;
        pos_reg   <= pos_next;
        sq_reg    <= sq_next;
        cross_reg <= cross_next;
        r_reg     <= r_next;
        num_reg   <= num_next;
    end

    // Ratio path. Each magnitude is divided by 4*r^2, which keeps the
    // remainder below the divisor from the first cell on; 30 quotient bits
    // then hold the Q3.28 value, and one more compare rounds it.
    logic [RATIO_REM_W-1:0]             rd_den [0:RATIO_STEPS];
    logic [LANES-1:0][RATIO_REM_W-1:0]  rd_rem [0:RATIO_STEPS];
    logic [LANES-1:0][RATIO_STEPS-1:0]  rd_quo [0:RATIO_STEPS];
    logic [RATIO_REM_W-1:0]             rd_den_reg;
    logic [LANES-1:0][RATIO_REM_W-1:0]  rd_rem_reg;
    logic [LANES-1:0][RATIO_REM_W-1:0]  rd_rem_next;
    logic [LANES-1:0]                   neg_reg;
    logic [LANES-1:0]                   neg_next;
    logic [LANES-1:0]                   neg_d;
    logic [LANES-1:0][NUM_W-1:0]        mag;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            neg_next[l]    = num_reg[l][NUM_W-1];
            mag[l]         = neg_next[l] ? (NUM_W'(0) - num_reg[l]) : num_reg[l];
            rd_rem_next[l] = RATIO_REM_W'(mag[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        rd_den_reg <= RATIO_REM_W'({r_reg, 2'b00});
        rd_rem_reg <= rd_rem_next;
        neg_reg    <= neg_next;
    end

    assign rd_den[0] = rd_den_reg;
    assign rd_rem[0] = rd_rem_reg;
    assign rd_quo[0] = '0;

    for (genvar j = 0; j < RATIO_STEPS; j++)
    begin : g_ratio
        ddtk_div_cell #(
            .LANES (LANES),
            .REM_W (RATIO_REM_W),
            .QUO_W (RATIO_STEPS)
        ) u_cell (
            .clk     (clk),
            .den     (rd_den[j]),
            .rem     (rd_rem[j]),
            .quo     (rd_quo[j]),
            .den_fwd (rd_den[j+1]),
            .rem_fwd (rd_rem[j+1]),
            .quo_fwd (rd_quo[j+1])
        );
    end

    ddtk_delay #(
        .W     (LANES),
        .DEPTH (RATIO_STEPS)
    ) u_neg_delay (
        .clk     (clk),
        .data    (neg_reg),
        .delayed (neg_d)
    );

    logic [LANES-1:0][RATIO_W-1:0] ratio_reg;
    logic [LANES-1:0][RATIO_W-1:0] ratio_next;
    logic [LANES-1:0][RATIO_W-1:0] ratio_mag;
    logic [LANES-1:0][RATIO_W-1:0] ratio_d;
    logic [LANES-1:0]              ratio_up;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            ratio_up[l]  = {rd_rem[RATIO_STEPS][l][RATIO_REM_W-2:0], 1'b0}
                           >= rd_den[RATIO_STEPS];
            ratio_mag[l] = RATIO_W'(rd_quo[RATIO_STEPS][l]) + RATIO_W'(ratio_up[l]);
            ratio_next[l] = neg_d[l] ? (RATIO_W'(0) - ratio_mag[l]) : ratio_mag[l];
        end
    end

    always_ff @(posedge clk)
    begin
        ratio_reg <= ratio_next;
    end

    ddtk_delay #(
        .W     (LANES * RATIO_W),
        .DEPTH (L_SDIV - L_RATIO)
    ) u_ratio_delay (
        .clk     (clk),
        .data    (ratio_reg),
        .delayed (ratio_d)
    );

    // Scale path, first part: r^2 is shifted left by an even count 2k until
    // it lies in [2^60, 2^62); each cell tries one power of two of k.
    logic [RN_W-1:0] nm_v [0:NORM_STEPS];
    logic [K_W-1:0]  nm_k [0:NORM_STEPS];

    assign nm_v[0] = RN_W'(r_reg);
    assign nm_k[0] = '0;

    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam int SH = 2 << (NORM_STEPS - 1 - j);
        logic [RN_W-1:0] v_reg;
        logic [RN_W-1:0] v_next;
        logic [K_W-1:0]  k_reg;
        logic [K_W-1:0]  k_next;

        always_comb
        begin
            if (nm_v[j][RN_W-1 -: SH] == '0)
            begin
                v_next = nm_v[j] << SH;
                k_next = nm_k[j] | K_W'(SH / 2);
            end
            else
            begin
                v_next = nm_v[j];
                k_next = nm_k[j];
            end
        end

        always_ff @(posedge clk)
        begin
            v_reg <= v_next;
            k_reg <= k_next;
        end

        assign nm_v[j+1] = v_reg;
        assign nm_k[j+1] = k_reg;
    end

    // Square root of the normalized value, one root bit per cell.
    logic [RN_W-1:0]       rt_rad  [0:SQRT_STEPS];
    logic [SQRT_REM_W-1:0] rt_rem  [0:SQRT_STEPS];
    logic [ROOT_W-1:0]     rt_root [0:SQRT_STEPS];

    assign rt_rad[0]  = nm_v[NORM_STEPS];
    assign rt_rem[0]  = '0;
    assign rt_root[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        ddtk_sqrt_cell #(
            .RAD_W  (RN_W),
            .REM_W  (SQRT_REM_W),
            .ROOT_W (ROOT_W)
        ) u_cell (
            .clk      (clk),
            .rad      (rt_rad[j]),
            .rem      (rt_rem[j]),
            .root     (rt_root[j]),
            .rad_fwd  (rt_rad[j+1]),
            .rem_fwd  (rt_rem[j+1]),
            .root_fwd (rt_root[j+1])
        );
    end

    logic [ROOT_W-1:0] rn_hi_d;
    logic [K_W-1:0]    k_d;

    ddtk_delay #(
        .W     (ROOT_W),
        .DEPTH (L_ROOT - L_NORM)
    ) u_rn_delay (
        .clk     (clk),
        .data    (nm_v[NORM_STEPS][RN_W-1 -: ROOT_W]),
        .delayed (rn_hi_d)
    );

    ddtk_delay #(
        .W     (K_W),
        .DEPTH (L_PROD - L_NORM)
    ) u_k_delay (
        .clk     (clk),
        .data    (nm_k[NORM_STEPS]),
        .delayed (k_d)
    );

    // r^3 scaled: the upper half of the normalized value times its root.
    logic [RN_W-1:0] prod_reg;
    logic [RN_W-1:0] prod_next;

    assign prod_next = RN_W'(rn_hi_d * rt_root[SQRT_STEPS]);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // The product's top bit sits at 59, 60 or 61. The divisor is the product
    // lifted to bit 61 and then doubled, so that 2^61 over it starts below it.
    logic [SCALE_REM_W-1:0] sden_reg;
    logic [SCALE_REM_W-1:0] sden_next;
    logic [EXPC_W-1:0]      exp_reg;
    logic [EXPC_W-1:0]      exp_next;
    logic [EXPC_W-1:0]      q_pos;
    logic [RN_W-1:0]        pn;
    logic [EXPC_W-1:0]      k_ext;

    always_comb
    begin
        priority if (prod_reg[RN_W-1])
        begin
            q_pos = EXPC_W'(RN_W - 1);
            pn    = prod_reg;
        end
        else if (prod_reg[RN_W-2])
        begin
            q_pos = EXPC_W'(RN_W - 2);
            pn    = prod_reg << 1;
        end
        else
        begin
            q_pos = EXPC_W'(RN_W - 3);
            pn    = prod_reg << 2;
        end
        k_ext     = EXPC_W'(k_d);
        sden_next = SCALE_REM_W'({pn, 1'b0});
        exp_next  = q_pos + EXPC_W'(MANT_W) - ({k_ext[EXPC_W-2:0], 1'b0} + k_ext);
    end

    always_ff @(posedge clk)
    begin
        sden_reg <= sden_next;
        exp_reg  <= exp_next;
    end

    logic [SCALE_REM_W-1:0]        sd_den [0:SCALE_STEPS];
    logic [0:0][SCALE_REM_W-1:0]   sd_rem [0:SCALE_STEPS];
    logic [0:0][SCALE_STEPS-1:0]   sd_quo [0:SCALE_STEPS];

    assign sd_den[0] = sden_reg;
    assign sd_rem[0] = SCALE_NUM;
    assign sd_quo[0] = '0;

    for (genvar j = 0; j < SCALE_STEPS; j++)
    begin : g_scale
        ddtk_div_cell #(
            .LANES (1),
            .REM_W (SCALE_REM_W),
            .QUO_W (SCALE_STEPS)
        ) u_cell (
            .clk     (clk),
            .den     (sd_den[j]),
            .rem     (sd_rem[j]),
            .quo     (sd_quo[j]),
            .den_fwd (sd_den[j+1]),
            .rem_fwd (sd_rem[j+1]),
            .quo_fwd (sd_quo[j+1])
        );
    end

    logic [EXPC_W-1:0] exp_d;
    logic              origin_d;

    ddtk_delay #(
        .W     (EXPC_W),
        .DEPTH (L_SDIV - L_QN)
    ) u_exp_delay (
        .clk     (clk),
        .data    (exp_reg),
        .delayed (exp_d)
    );

    ddtk_delay #(
        .W     (1),
        .DEPTH (L_SDIV - L_R)
    ) u_origin_delay (
        .clk     (clk),
        .data    (r_reg == '0),
        .delayed (origin_d)
    );

    // Output stage: round the reciprocal, fold a carry out into the
    // exponent, and force zeros when r^2 is zero.
    result_t           result_reg;
    result_t           result_next;
    logic              scale_up;
    logic [MANT_W:0]   scale_q;
    logic [MANT_W-1:0] mant;
    logic [EXPC_W-1:0] expo;

    always_comb
    begin
        scale_up = {sd_rem[SCALE_STEPS][0][SCALE_REM_W-2:0], 1'b0} >= sd_den[SCALE_STEPS];
        scale_q  = (MANT_W+1)'(sd_quo[SCALE_STEPS][0]) + (MANT_W+1)'(scale_up);
        if (scale_q[MANT_W])
        begin
            mant = MANT_W'(1) << (MANT_W - 1);
            expo = exp_d - EXPC_W'(1);
        end
        else
        begin
            mant = scale_q[MANT_W-1:0];
            expo = exp_d;
        end
        if (origin_d)
        begin
            result_next           = '0;
            result_next.at_origin = 1'b1;
        end
        else
        begin
            result_next.ratio_xx       = ratio_d[LANE_XX];
            result_next.ratio_yy       = ratio_d[LANE_YY];
            result_next.ratio_zz       = ratio_d[LANE_ZZ];
            result_next.ratio_xy       = ratio_d[LANE_XY];
            result_next.ratio_xz       = ratio_d[LANE_XZ];
            result_next.ratio_yz       = ratio_d[LANE_YZ];
            result_next.scale_mantissa = mant;
            result_next.scale_exponent = expo[EXP_W-1:0];
            result_next.at_origin      = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = valid_reg[LAT-1];
    assign result = result_reg;

    // Every result beat traces back to a beat taken a fixed time earlier.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result beat without a matching input beat");

    // Away from the origin the mantissa is normalized.
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.at_origin) |-> result.scale_mantissa[MANT_W-1])
        else $error("scale mantissa not normalized");

    // At the origin everything but the flag is zero.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.at_origin) |->
            (result.scale_mantissa == '0 && result.scale_exponent == '0 &&
             result.ratio_xx == '0 && result.ratio_xy == '0))
        else $error("origin result not cleared");

endmodule
